FILE: rtl/core/sm4_pkg.sv
// Shared types, constants and table functions for the SM4 block cipher core.
`timescale 1ns / 1ps
`default_nettype none

package sm4_pkg;

    // Number of rounds and the width of a round counter.
    localparam int SM4_ROUNDS = 32;
    localparam int SM4_CNT_W  = $clog2(SM4_ROUNDS);

    // Configuration register indexes.
    localparam int SM4_CFG_IDX_W = 1;
    localparam logic [SM4_CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [SM4_CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;

    // Input command codes carried on tuser.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Key whitening words.
    localparam logic [31:0] SM4_FK [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    // Nonlinear byte substitution table.
    localparam logic [7:0] SM4_SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_KLOAD,
        ST_KEXP,
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    // Write port of the round key store.
    typedef struct packed {
        logic                 en;
        logic [SM4_CNT_W-1:0] addr;
        logic [31:0]          data;
    } t_rk_wr;

    // Substitute all four bytes of a word.
    function automatic logic [31:0] sm4_tau(input logic [31:0] a);
        sm4_tau = {SM4_SBOX[a[31:24]], SM4_SBOX[a[23:16]], SM4_SBOX[a[15:8]], SM4_SBOX[a[7:0]]};
    endfunction

    // Key schedule constant: byte j of word i is (4i + j) * 7 modulo 256.
    function automatic logic [31:0] sm4_ck_word(input logic [SM4_CNT_W-1:0] i);
        logic [7:0]  base;
        logic [31:0] w;
        base = 8'(i) << 2;
        w    = '0;
        for (int j = 0; j < 4; j++) begin
            w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
        end
        sm4_ck_word = w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sm4_round.sv
// Shared SM4 round function used for both the key schedule and the data rounds.
`timescale 1ns / 1ps
`default_nettype none

module sm4_round
    import sm4_pkg::*;
(
    input  wire logic [31:0] i_word0,
    input  wire logic [31:0] i_word1,
    input  wire logic [31:0] i_word2,
    input  wire logic [31:0] i_word3,
    input  wire logic [31:0] i_rkey,
    input  wire logic        i_key_mode,
    output logic [31:0]      o_word
);

    logic [31:0] w_mix;
    logic [31:0] w_sub;
    logic [31:0] w_lin_data;
    logic [31:0] w_lin_key;

    // Mix the three newest words with the round key and substitute bytes.
    assign w_mix = i_word1 ^ i_word2 ^ i_word3 ^ i_rkey;
    assign w_sub = sm4_tau(w_mix);

    // Linear diffusion for the data path: rotations by 2, 10, 18 and 24.
    assign w_lin_data = w_sub
                      ^ {w_sub[29:0], w_sub[31:30]}
                      ^ {w_sub[21:0], w_sub[31:22]}
                      ^ {w_sub[13:0], w_sub[31:14]}
                      ^ {w_sub[7:0],  w_sub[31:8]};

    // Linear diffusion for the key schedule: rotations by 13 and 23.
    assign w_lin_key = w_sub
                     ^ {w_sub[18:0], w_sub[31:19]}
                     ^ {w_sub[8:0],  w_sub[31:9]};

    assign o_word = i_word0 ^ (i_key_mode ? w_lin_key : w_lin_data);

endmodule

`default_nettype wire

FILE: rtl/core/sm4_rk_mem.sv
// Round key store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sm4_rk_mem
    import sm4_pkg::*;
#(
    parameter int ROUNDS = SM4_ROUNDS
) (
    input  wire logic                      i_clk,
    input  wire t_rk_wr                    i_wr,
    input  wire logic [$clog2(ROUNDS)-1:0] i_rd_addr,
    output logic [31:0]                    o_rd_data
);

    logic [31:0] r_mem [ROUNDS];
    logic [31:0] r_rd_data;

    // Write one round key per cycle during expansion.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read, issued in the cycle before its use.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/core/sm4_block_cipher.sv
// Top level of the SM4 block cipher core: sequencer, state words and output register.
//
// Usage:
//   Configuration: i_cfg_we writes i_cfg_data to key_high (index 0) or key_low (index 1).
//   Every write restarts the key expansion, which fills the round key store;
//   s_axis_tready stays low meanwhile. Write keys only while the core is idle.
//   Input channel: s_axis_tdata carries the block, s_axis_tuser the command
//   (0 encrypt, 1 decrypt). One transaction is one 128-bit block.
//   Output channel: m_axis_tdata carries the processed block, words in reversed order.
//   Processing: each block runs its rounds one after another on the single shared
//   round unit, which reads one round key per cycle from the key store; a finishing
//   step then moves the result into the output register.
//   The core takes a new block only once the previous one has left its finishing
//   step, and takes it while a finished result still waits in the output register.
//   Reset: the key registers clear to zero and the round keys of the all-zero key are
//   expanded at once, so the input channel opens once that expansion is done.
//   Stall: if the receiver holds m_axis_tready low, the output register keeps its
//   transaction and the following block waits after its last round until it frees.
`timescale 1ns / 1ps
`default_nettype none

module sm4_block_cipher
    import sm4_pkg::*;
#(
    parameter int ROUNDS = SM4_ROUNDS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Configuration write port
    input  wire logic                     i_cfg_we,
    input  wire logic [SM4_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]              i_cfg_data,
    // Input stream
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [127:0]             s_axis_tdata,  // [63:0] block_high, [127:64] block_low
    input  wire logic                     s_axis_tuser,  // [0] command
    // Output stream
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [127:0]                  m_axis_tdata   // [63:0] result_high, [127:64] result_low
);

    localparam int CNT_W = $clog2(ROUNDS);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(ROUNDS - 1);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_dec;
    logic [63:0]        r_key_high;
    logic [63:0]        r_key_low;
    logic [31:0]        r_x0, r_x1, r_x2, r_x3;
    logic [31:0]        n_x0, n_x1, n_x2, n_x3;
    logic               r_out_valid;
    logic [127:0]       r_out_data;

    logic               w_in_accept;
    logic               w_out_free;
    logic               w_last;
    logic [31:0]        w_rkey;
    logic [31:0]        w_round_out;
    logic [31:0]        w_rk_rd_data;
    logic [CNT_W-1:0]   w_rd_addr;
    t_rk_wr             w_rk_wr;

    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_last      = (r_cnt == LAST_IDX);

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_KLOAD: n_state = ST_KEXP;
            ST_KEXP:  if (w_last) n_state = ST_IDLE;
            ST_IDLE:  if (w_in_accept) n_state = ST_RUN;
            ST_RUN:   if (w_last) n_state = ST_FIN;
            ST_FIN:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_KLOAD;
        endcase
        if (i_cfg_we) begin
            n_state = ST_KLOAD;
        end
    end

    // Sequencer outputs: counter, key selection and store addressing.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        n_cnt         = '0;
        w_rkey        = w_rk_rd_data;
        w_rd_addr     = '0;
        w_rk_wr.en    = 1'b0;
        w_rk_wr.addr  = r_cnt;
        w_rk_wr.data  = w_round_out;
        case (r_state)
            ST_KEXP: begin
                n_cnt      = w_last ? '0 : r_cnt + 1'b1;
                w_rkey     = sm4_ck_word(SM4_CNT_W'(r_cnt));
                w_rk_wr.en = 1'b1;
            end
            ST_IDLE: begin
                w_rd_addr = (s_axis_tuser == CMD_DECRYPT) ? LAST_IDX : '0;
            end
            ST_RUN: begin
                n_cnt     = w_last ? '0 : r_cnt + 1'b1;
                w_rd_addr = r_dec ? (LAST_IDX - r_cnt - 1'b1) : (r_cnt + 1'b1);
            end
            default: ;
        endcase
    end

    // Next values of the four state words.
    always_comb begin
        n_x0 = r_x0;
        n_x1 = r_x1;
        n_x2 = r_x2;
        n_x3 = r_x3;
        case (r_state)
            ST_KLOAD: begin
                n_x0 = r_key_high[63:32] ^ SM4_FK[0];
                n_x1 = r_key_high[31:0]  ^ SM4_FK[1];
                n_x2 = r_key_low[63:32]  ^ SM4_FK[2];
                n_x3 = r_key_low[31:0]   ^ SM4_FK[3];
            end
            ST_KEXP, ST_RUN: begin
                n_x0 = r_x1;
                n_x1 = r_x2;
                n_x2 = r_x3;
                n_x3 = w_round_out;
            end
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_x0 = s_axis_tdata[63:32];
                    n_x1 = s_axis_tdata[31:0];
                    n_x2 = s_axis_tdata[127:96];
                    n_x3 = s_axis_tdata[95:64];
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_KLOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if ((r_state == ST_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_x0 <= n_x0;
        r_x1 <= n_x1;
        r_x2 <= n_x2;
        r_x3 <= n_x3;
        if (w_in_accept) begin
            r_dec <= s_axis_tuser;
        end
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_data <= {r_x1, r_x0, r_x3, r_x2};
        end
    end

    sm4_round u_round (
        .i_word0    (r_x0),
        .i_word1    (r_x1),
        .i_word2    (r_x2),
        .i_word3    (r_x3),
        .i_rkey     (w_rkey),
        .i_key_mode (r_state == ST_KEXP),
        .o_word     (w_round_out)
    );

    sm4_rk_mem #(
        .ROUNDS (ROUNDS)
    ) u_rk_mem (
        .i_clk     (i_clk),
        .i_wr      (w_rk_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rk_rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The last data round leads to the finishing step unless a key write intervenes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && w_last && !i_cfg_we |=> r_state == ST_FIN)
        else $error("last round did not lead to the finishing step");

    // An accepted transaction starts its rounds at the first round.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && !i_cfg_we |=> (r_state == ST_RUN) && (r_cnt == '0))
        else $error("accepted block did not start at round zero");

    // A key write always restarts the expansion.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_state == ST_KLOAD)
        else $error("key write did not restart the expansion");

    // The finishing step never overwrites a result that is still waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && r_out_valid && !m_axis_tready && !i_cfg_we
        |=> (r_state == ST_FIN) && $stable(r_out_data))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: dv/sm4_cipher_checker.sv
// Channel monitor, SM4 cipher predictor and result comparison for the SM4 block cipher.
`timescale 1ns / 1ps

module sm4_cipher_checker
    import sm4_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SM4_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]              i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [127:0]             i_in_data,   // [63:0] block_high, [127:64] block_low
    input  logic                     i_in_cmd,    // [0] command
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [127:0]             i_out_data,  // [63:0] result_high, [127:64] result_low
    output int                       o_pending,
    output int                       o_mismatches
);

    // Packed so that the first field sits in the high bits, as on the bus.
    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
    } cipher_block_t;

    // Published SM4 substitution table.
    localparam logic [7:0] SUBST_BYTE [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Key whitening words of the key schedule.
    localparam logic [31:0] KEY_WHITEN [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    logic [63:0]   cipher_key_high;
    logic [63:0]   cipher_key_low;
    logic [31:0]   round_key [SM4_ROUNDS];
    cipher_block_t cipher_results_due [$];
    cipher_block_t due_block;
    cipher_block_t seen_block;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] a);
        return {SUBST_BYTE[a[31:24]], SUBST_BYTE[a[23:16]], SUBST_BYTE[a[15:8]], SUBST_BYTE[a[7:0]]};
    endfunction

    // Round constant of the key schedule: byte j of word i is (4i + j) * 7, truncated to 8 bits.
    function automatic logic [31:0] schedule_const(input int unsigned i);
        logic [31:0] w;
        w = '0;
        for (int unsigned j = 0; j < 4; j++) begin
            w = {w[23:0], 8'((4 * i + j) * 7)};
        end
        return w;
    endfunction

    // Rebuild all round keys from the two key halves.
    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] t;
        logic [31:0] nk;
        k[0] = cipher_key_high[63:32] ^ KEY_WHITEN[0];
        k[1] = cipher_key_high[31:0]  ^ KEY_WHITEN[1];
        k[2] = cipher_key_low[63:32]  ^ KEY_WHITEN[2];
        k[3] = cipher_key_low[31:0]   ^ KEY_WHITEN[3];
        for (int unsigned i = 0; i < SM4_ROUNDS; i++) begin
            t  = subst_word(k[1] ^ k[2] ^ k[3] ^ schedule_const(i));
            nk = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
            round_key[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
    endfunction

    // Full 32-round transform; decryption walks the round keys backward.
    function automatic cipher_block_t crypt_block(input logic cmd, input logic [63:0] blk_high,
                                                  input logic [63:0] blk_low);
        logic [31:0]   x [4];
        logic [31:0]   t;
        logic [31:0]   nx;
        cipher_block_t r;
        x[0] = blk_high[63:32];
        x[1] = blk_high[31:0];
        x[2] = blk_low[63:32];
        x[3] = blk_low[31:0];
        for (int unsigned i = 0; i < SM4_ROUNDS; i++) begin
            t  = x[1] ^ x[2] ^ x[3] ^
                 ((cmd == CMD_DECRYPT) ? round_key[SM4_ROUNDS - 1 - i] : round_key[i]);
            t  = subst_word(t);
            nx = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        r.result_high = {x[3], x[2]};
        r.result_low  = {x[1], x[0]};
        return r;
    endfunction

    initial o_mismatches = 0;

    // Track key writes, predict each accepted block and check each delivered one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cipher_key_high = '0;
            cipher_key_low  = '0;
            expand_round_keys();
            cipher_results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY_HIGH: cipher_key_high = i_cfg_data;
                    CFG_KEY_LOW:  cipher_key_low  = i_cfg_data;
                    default: ;
                endcase
                expand_round_keys();
            end
            if (i_in_valid && i_in_ready) begin
                cipher_results_due.push_back(crypt_block(i_in_cmd, i_in_data[63:0],
                                                         i_in_data[127:64]));
            end
            if (i_out_valid && i_out_ready) begin
                seen_block = i_out_data;
                if (cipher_results_due.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    $display("%0t: unexpected result transaction, expected none, got %h",
                             $time, i_out_data);
                end else begin
                    due_block = cipher_results_due.pop_front();
                    if (seen_block.result_high !== due_block.result_high) begin
                        o_mismatches = o_mismatches + 1;
                        $display("%0t: result_high expected %h, got %h", $time,
                                 due_block.result_high, seen_block.result_high);
                    end
                    if (seen_block.result_low !== due_block.result_low) begin
                        o_mismatches = o_mismatches + 1;
                        $display("%0t: result_low expected %h, got %h", $time,
                                 due_block.result_low, seen_block.result_low);
                    end
                end
            end
            o_pending <= cipher_results_due.size();
        end
    end

endmodule

FILE: dv/sm4_block_cipher_test.sv
// Top of the SM4 block cipher testbench: clock, reset, key writes, block stimulus and verdict.
`timescale 1ns / 1ps

module sm4_block_cipher_test;

    import sm4_pkg::*;

    localparam int RANDOM_PHASES    = 8;
    localparam int BLOCKS_PER_PHASE = 167;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [SM4_CFG_IDX_W-1:0] i_cfg_index   = CFG_KEY_HIGH;
    logic [63:0]              i_cfg_data    = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [127:0]             s_axis_tdata  = '0;  // [63:0] block_high, [127:64] block_low
    logic                     s_axis_tuser  = CMD_ENCRYPT;  // [0] command
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b1;
    logic [127:0]             m_axis_tdata;  // [63:0] result_high, [127:64] result_low

    int blocks_in_flight;
    int mismatch_count;
    int gap_pct   = 0;
    int stall_pct = 0;

    sm4_block_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sm4_cipher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_cmd     (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_pending    (blocks_in_flight),
        .o_mismatches (mismatch_count)
    );

    always #1 i_clk = ~i_clk;

    // Receiver back-pressure at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one block after a random gap and hold it until the transaction completes.
    task automatic send_block(input logic cmd, input logic [63:0] blk_high,
                              input logic [63:0] blk_low);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {blk_low, blk_high};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and let every outstanding block come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (blocks_in_flight != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key_reg(input logic [SM4_CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Half a block: fully random, or built from all-zero, all-one and random words.
    function automatic logic [63:0] random_half(input bit corner_words);
        logic [31:0] w [2];
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(2))
                0:       w[i] = corner_words ? 32'h0 : $urandom;
                1:       w[i] = corner_words ? 32'hffffffff : $urandom;
                default: w[i] = $urandom;
            endcase
        end
        return {w[0], w[1]};
    endfunction

    // Stimulus: directed blocks and key writes, then random phases with varying idling.
    initial begin
        bit corner;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Blocks before any key write run under the all-zero key.
        send_block(CMD_ENCRYPT, 64'h0, 64'h0);
        send_block(CMD_DECRYPT, 64'h0, 64'h0);
        send_block(CMD_ENCRYPT, '1, '1);
        send_block(CMD_DECRYPT, '1, '1);
        send_block(CMD_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(CMD_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(CMD_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        send_block(CMD_DECRYPT, 64'h0000000000000001, 64'h8000000000000000);

        // Example vector of the standard, both directions.
        wait_idle();
        write_key_reg(CFG_KEY_HIGH, 64'h0123456789abcdef);
        write_key_reg(CFG_KEY_LOW, 64'hfedcba9876543210);
        send_block(CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(CMD_DECRYPT, 64'h681edf34d206965e, 64'h86b3e94f536e4246);

        // A single half written takes effect on its own.
        wait_idle();
        write_key_reg(CFG_KEY_HIGH, '1);
        send_block(CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(CMD_DECRYPT, '1, 64'h0);
        wait_idle();
        write_key_reg(CFG_KEY_LOW, '1);
        send_block(CMD_ENCRYPT, 64'h0, '1);
        send_block(CMD_DECRYPT, '1, '1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            if (p == RANDOM_PHASES - 2) begin
                write_key_reg(CFG_KEY_HIGH, 64'h0);
                write_key_reg(CFG_KEY_LOW, 64'h0);
            end else begin
                case (p % 3)
                    0: begin
                        write_key_reg(CFG_KEY_HIGH, {$urandom, $urandom});
                        write_key_reg(CFG_KEY_LOW, {$urandom, $urandom});
                    end
                    1:       write_key_reg(CFG_KEY_HIGH, {$urandom, $urandom});
                    default: write_key_reg(CFG_KEY_LOW, {$urandom, $urandom});
                endcase
            end
            case (p % 4)
                0: begin
                    gap_pct    = 0;
                    stall_pct <= 0;
                end
                1: begin
                    gap_pct    = 55;
                    stall_pct <= 0;
                end
                2: begin
                    gap_pct    = 0;
                    stall_pct <= 55;
                end
                default: begin
                    gap_pct    = 16;
                    stall_pct <= 16;
                end
            endcase
            for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
                corner = ($urandom_range(7) == 0);
                send_block(1'($urandom_range(1)), random_half(corner), random_half(corner));
            end
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a lost result.
    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
